### sv/rgbsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbsd_pkg
// shared types, constants and helpers of the rgb square dilation block
// ----------------------------------------------------------------------------
package rgbsd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 15;

  localparam int PIX_W     = 24;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int WSIZE_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic [CFG_W-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0]   RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE  = 5'd30;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic       frame_last;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // per channel maximum of two packed pixels
  function automatic logic [PIX_W-1:0] pix_max(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] m;
    for (int c = 0; c < 3; c++) begin
      m[c*8 +: 8] = (a[c*8 +: 8] > b[c*8 +: 8]) ? a[c*8 +: 8] : b[c*8 +: 8];
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/rgbsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbsd_if
// valid/ready channels for pixel words and result words
// ----------------------------------------------------------------------------
interface rgbsd_in_if;
  logic                valid;
  logic                ready;
  rgbsd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgbsd_out_if;
  logic                 valid;
  logic                 ready;
  rgbsd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/rgb_square_dilation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_square_dilation
// per channel square window maximum over a raster pixel stream
// ----------------------------------------------------------------------------
// sequence: each accepted word passes S_MUL and S_CMP; a due result then
//   runs S_BASE, then per column S_SEL, S_COL (reads on the single read port
//   of the line store) and S_COLEND, a column past the right edge shifting
//   in zero, then S_RED over the cell chain and S_OUT, which waits out any output stall
// throughput: one word at a time; first result of a row loads r+1 columns,
//   the others load one column
// reset: synchronous active-low; counters to zero, registers to defaults,
//   line store keeps its contents (only read after written)
// ----------------------------------------------------------------------------
module rgb_square_dilation #(
  parameter int MAX_WIDTH  = rgbsd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbsd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = rgbsd_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rgbsd_in_if.sink                               in_ch,
  rgbsd_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rgbsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgbsd_pkg::CFG_W-1:0]       cfg_wdata
);
  localparam int NCELL = 2 * MAX_RADIUS + 1;
  localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int BW    = ((AW > PW) ? AW : PW) + 2;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CNTW  = $clog2(NCELL + 1);
  localparam int PIX_W = rgbsd_pkg::PIX_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_BASE   = 4'd3;
  localparam logic [3:0] S_SEL    = 4'd4;
  localparam logic [3:0] S_COL    = 4'd5;
  localparam logic [3:0] S_COLEND = 4'd6;
  localparam logic [3:0] S_RED    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  // configuration registers
  logic [rgbsd_pkg::CFG_W-1:0]   cfg_width_r, cfg_height_r;
  logic [rgbsd_pkg::WSIZE_W-1:0] cfg_wsize_r;
  logic                          cfg_hit;

  // effective frame geometry
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;

  // position counters
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [AW-1:0] arrived_r, arrived_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  // sequencer
  logic [3:0]      state_r, state_nxt;
  logic [AW-1:0]   prod_need_r, prod_need_nxt;
  logic [AW-1:0]   prod_y0_r, prod_y0_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [PW-1:0]   base_r, base_nxt;
  logic [XW-1:0]   col_r, col_nxt;
  logic [XW-1:0]   col_end_r, col_end_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [PW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [PIX_W-1:0] colmax_r, colmax_nxt;
  logic [CNTW-1:0] red_cnt_r, red_cnt_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  rgbsd_pkg::out_word_t out_data_r, out_data_nxt;

  // line store
  logic [PIX_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] rdata_r;

  // cell chain
  rgbsd_pkg::cell_ctl_t cell_ctl;
  logic [PIX_W-1:0]     cell_in;
  logic [PIX_W-1:0]     win_max;

  // window geometry of the next result
  logic [XW-1:0] w_x, out_col_x, r_x, need_col, x0;
  logic [YW-1:0] h_y, out_row_y, r_y, need_row, y0;
  logic          in_fire, pix_take, frame_last;
  logic [BW-1:0] base_sum;
  logic [PW:0]   col_addr, step_addr;

  assign cfg_hit = cfg_we && (cfg_index == rgbsd_pkg::CFG_IMAGE_WIDTH ||
                              cfg_index == rgbsd_pkg::CFG_IMAGE_HEIGHT ||
                              cfg_index == rgbsd_pkg::CFG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= rgbsd_pkg::RST_IMAGE_WIDTH;
      cfg_height_r <= rgbsd_pkg::RST_IMAGE_HEIGHT;
      cfg_wsize_r  <= rgbsd_pkg::RST_WINDOW_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbsd_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata;
        rgbsd_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata;
        rgbsd_pkg::CFG_WINDOW_SIZE:  cfg_wsize_r  <= cfg_wdata[rgbsd_pkg::WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate geometry to the supported range
  always_comb begin
    if (cfg_width_r == '0) w_eff = WW'(1);
    else if (32'(cfg_width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_width_r);
    if (cfg_height_r == '0) h_eff = HW'(1);
    else if (32'(cfg_height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_height_r);
    // even sizes share the radius of the next odd size
    if (32'(cfg_wsize_r[rgbsd_pkg::WSIZE_W-1:1]) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(cfg_wsize_r[rgbsd_pkg::WSIZE_W-1:1]);
  end

  // clipped window bounds of the result at (out_row, out_col)
  always_comb begin
    w_x       = XW'(w_eff);
    out_col_x = XW'(out_col_r);
    r_x       = XW'(r_eff);
    h_y       = YW'(h_eff);
    out_row_y = YW'(out_row_r);
    r_y       = YW'(r_eff);
    need_col  = (out_col_x + r_x < w_x - XW'(1)) ? out_col_x + r_x : w_x - XW'(1);
    x0        = (out_col_x >= r_x) ? out_col_x - r_x : '0;
    need_row  = (out_row_y + r_y < h_y - YW'(1)) ? out_row_y + r_y : h_y - YW'(1);
    y0        = (out_row_y >= r_y) ? out_row_y - r_y : '0;
  end

  assign frame_last = (HW'(out_row_r) == h_eff - HW'(1)) &&
                      (WW'(out_col_r) == w_eff - WW'(1));
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // a pixel past the frame's last row is dropped and acts as a drain
  assign pix_take    = in_fire && (in_ch.data.operation == rgbsd_pkg::OP_PIXEL) &&
                       (in_row_r < h_eff);
  assign mem_we      = pix_take;
  assign mem_wdata   = {in_ch.data.chan2_in, in_ch.data.chan1_in, in_ch.data.chan0_in};

  // ring position of the window's top left pixel, relative to the write pointer
  assign base_sum  = BW'(wr_ptr_r) + BW'(DEPTH) - BW'(arrived_r - idx_r);
  assign col_addr  = (PW+1)'(base_r) + (PW+1)'(col_r - x0);
  assign step_addr = (PW+1)'(rd_addr_r) + (PW+1)'(w_eff);

  always_comb begin
    state_nxt     = state_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    arrived_nxt   = arrived_r;
    wr_ptr_nxt    = wr_ptr_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    prod_need_nxt = prod_need_r;
    prod_y0_nxt   = prod_y0_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    col_end_nxt   = col_end_r;
    y_nxt         = y_r;
    rd_addr_nxt   = rd_addr_r;
    rd_vld_nxt    = 1'b0;
    colmax_nxt    = colmax_r;
    red_cnt_nxt   = red_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    cell_ctl      = '0;
    cell_in       = '0;

    if (rd_vld_r && state_r == S_COL) begin
      colmax_nxt = rgbsd_pkg::pix_max(colmax_r, rdata_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (pix_take) begin
            arrived_nxt = arrived_r + AW'(1);
            wr_ptr_nxt  = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
            if (WW'(in_col_r) == w_eff - WW'(1)) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + HW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
          end
          state_nxt = (out_row_r < h_eff) ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        prod_need_nxt = AW'(AW'(need_row) * AW'(w_eff));
        prod_y0_nxt   = AW'(AW'(y0) * AW'(w_eff));
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        // result due once the window's last pixel has arrived
        idx_nxt = prod_y0_r + AW'(x0);
        if (arrived_r > prod_need_r + AW'(need_col)) state_nxt = S_BASE;
        else state_nxt = S_IDLE;
      end
      S_BASE: begin
        base_nxt = (base_sum >= BW'(DEPTH)) ? PW'(base_sum - BW'(DEPTH)) : PW'(base_sum);
        if (out_col_r == '0) begin
          // row start: empty chain, preload columns 0..r
          cell_ctl.clear = 1'b1;
          col_nxt        = '0;
          col_end_nxt    = r_x;
        end else begin
          col_nxt     = out_col_x + r_x;
          col_end_nxt = out_col_x + r_x;
        end
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (col_r >= w_x) begin
          // column beyond the right edge reads as zero
          cell_ctl.shift = 1'b1;
          if (col_r == col_end_r) begin
            red_cnt_nxt = '0;
            state_nxt   = S_RED;
          end else begin
            col_nxt = col_r + XW'(1);
          end
        end else begin
          y_nxt       = y0;
          rd_addr_nxt = (col_addr >= (PW+1)'(DEPTH)) ? PW'(col_addr - (PW+1)'(DEPTH))
                                                     : PW'(col_addr);
          colmax_nxt  = '0;
          state_nxt   = S_COL;
        end
      end
      S_COL: begin
        rd_vld_nxt  = 1'b1;
        rd_addr_nxt = (step_addr >= (PW+1)'(DEPTH)) ? PW'(step_addr - (PW+1)'(DEPTH))
                                                    : PW'(step_addr);
        if (y_r == need_row) state_nxt = S_COLEND;
        else y_nxt = y_r + YW'(1);
      end
      S_COLEND: begin
        cell_ctl.shift = 1'b1;
        cell_in        = rgbsd_pkg::pix_max(colmax_r, rdata_r);
        if (col_r == col_end_r) begin
          red_cnt_nxt = '0;
          state_nxt   = S_RED;
        end else begin
          col_nxt   = col_r + XW'(1);
          state_nxt = S_SEL;
        end
      end
      S_RED: begin
        // running max ripples cell by cell to the chain end
        if (32'(red_cnt_r) == NCELL) state_nxt = S_OUT;
        else red_cnt_nxt = red_cnt_r + CNTW'(1);
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.chan0_out  = win_max[7:0];
          out_data_nxt.chan1_out  = win_max[15:8];
          out_data_nxt.chan2_out  = win_max[23:16];
          out_data_nxt.frame_last = frame_last;
          if (frame_last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            arrived_nxt = '0;
            wr_ptr_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (WW'(out_col_r) == w_eff - WW'(1)) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + HW'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register write restarts the frame
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      arrived_nxt = '0;
      wr_ptr_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      state_nxt   = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      arrived_r   <= '0;
      wr_ptr_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      rd_vld_r    <= 1'b0;
      red_cnt_r   <= '0;
      col_r       <= '0;
      col_end_r   <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      arrived_r   <= arrived_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      rd_vld_r    <= rd_vld_nxt;
      red_cnt_r   <= red_cnt_nxt;
      col_r       <= col_nxt;
      col_end_r   <= col_end_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_need_r <= prod_need_nxt;
    prod_y0_r   <= prod_y0_nxt;
    idx_r       <= idx_nxt;
    base_r      <= base_nxt;
    rd_addr_r   <= rd_addr_nxt;
    colmax_r    <= colmax_nxt;
    out_data_r  <= out_data_nxt;
  end

  // line store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr_r];
  end

  rgbsd_cell_row #(
    .NCELL (NCELL),
    .RW    (RW)
  ) u_cell_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cell_ctl),
    .radius (r_eff),
    .in_val (cell_in),
    .max_o  (win_max)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // store reads are only issued by the column scan
  a_rd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == S_COL)
    else $error("line store read outside column scan");

  // the write pointer stays inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wr_ptr_r) < DEPTH)
    else $error("write pointer out of range");

  // a frame's last word restarts the input side
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE && frame_last && !cfg_hit)
      |=> (in_row_r == '0 && in_col_r == '0 && arrived_r == '0))
    else $error("frame end did not restart counters");

endmodule
`default_nettype wire

### sv/rgbsd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbsd_cell
// one column-maximum cell: holds a column, passes it on, folds a running max
// ----------------------------------------------------------------------------
module rgbsd_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rgbsd_pkg::cell_ctl_t       ctl,
  input  wire logic                       en,
  input  wire logic [rgbsd_pkg::PIX_W-1:0] left_val,
  input  wire logic [rgbsd_pkg::PIX_W-1:0] left_acc,
  output logic      [rgbsd_pkg::PIX_W-1:0] val_o,
  output logic      [rgbsd_pkg::PIX_W-1:0] acc_o
);
  logic [rgbsd_pkg::PIX_W-1:0] val_r, val_nxt;
  logic [rgbsd_pkg::PIX_W-1:0] acc_r, acc_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.shift) begin
      val_nxt = left_val;
    end
    acc_nxt = rgbsd_pkg::pix_max(left_acc, en ? val_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      acc_r <= '0;
    end else begin
      val_r <= val_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign val_o = val_r;
  assign acc_o = acc_r;
endmodule
`default_nettype wire

### sv/rgbsd_cell_row.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbsd_cell_row
// chain of column cells; newest column enters cell 0, max ripples to the end
// ----------------------------------------------------------------------------
module rgbsd_cell_row #(
  parameter int NCELL = 2 * rgbsd_pkg::DEF_MAX_RADIUS + 1,
  parameter int RW    = $clog2(rgbsd_pkg::DEF_MAX_RADIUS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rgbsd_pkg::cell_ctl_t        ctl,
  input  wire logic [RW-1:0]               radius,
  input  wire logic [rgbsd_pkg::PIX_W-1:0] in_val,
  output logic      [rgbsd_pkg::PIX_W-1:0] max_o
);
  logic [rgbsd_pkg::PIX_W-1:0] val_w [NCELL+1];
  logic [rgbsd_pkg::PIX_W-1:0] acc_w [NCELL+1];

  assign val_w[0] = in_val;
  assign acc_w[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic en;
    // only the last 2r+1 columns belong to the window
    assign en = (i <= 2 * int'(radius));
    rgbsd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .en       (en),
      .left_val (val_w[i]),
      .left_acc (acc_w[i]),
      .val_o    (val_w[i+1]),
      .acc_o    (acc_w[i+1])
    );
  end

  assign max_o = acc_w[NCELL];
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb square dilation block: frames of random
// and directed pixels under many geometries, checked word by word against a
// window-maximum predictor, with bursty input and a stalling result side
// ----------------------------------------------------------------------------
module testbench;
  import rgbsd_pkg::*;

  localparam int HIST_DEPTH  = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
  localparam int IDLE_LIMIT  = 20000;   // cycles without any handshake
  localparam int CFG_SETTLE  = 64;      // covers the tail of result-less words
  localparam int HOLD_CYCLES = 600;     // long result-side hold-off

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  rgbsd_in_if  in_ch ();
  rgbsd_out_if out_ch ();

  rgb_square_dilation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // words waiting for the driver, results the block owes us
  in_word_t  pixel_words_q[$];
  out_word_t due_results_q[$];

  int errors = 0;
  int words_in = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int phases_run = 0;

  // ---------------------------------------------------------------------------
  // dilation predictor: own copy of registers, counters and pixel history
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pix_hist [HIST_DEPTH];
  int unsigned reg_width  = RST_IMAGE_WIDTH;
  int unsigned reg_height = RST_IMAGE_HEIGHT;
  int unsigned reg_wsize  = RST_WINDOW_SIZE;
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  bit frame_closed;

  function automatic int unsigned eff_w();
    if (reg_width == 0) return 1;
    return (reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_height == 0) return 1;
    return (reg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : reg_height;
  endfunction

  function automatic int unsigned eff_r();
    return (reg_wsize / 2 > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : reg_wsize / 2;
  endfunction

  // apply one accepted word; owed result, if any, goes to due_results_q
  task automatic dilate_step(input in_word_t wd);
    int unsigned w, h, r, arrived, need_row, need_col, y0, x0;
    logic [7:0] m0, m1, m2;
    logic [PIX_W-1:0] p;
    out_word_t res;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    frame_closed = 1'b0;
    if (wd.operation == OP_PIXEL && in_row < h) begin
      pix_hist[(in_row * w + in_col) % HIST_DEPTH] = {wd.chan2_in, wd.chan1_in, wd.chan0_in};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (out_row >= h) return;
    arrived  = in_row * w + in_col;
    need_row = (out_row + r < h - 1) ? out_row + r : h - 1;
    need_col = (out_col + r < w - 1) ? out_col + r : w - 1;
    if (arrived <= need_row * w + need_col) return;
    y0 = (out_row >= r) ? out_row - r : 0;
    x0 = (out_col >= r) ? out_col - r : 0;
    m0 = '0; m1 = '0; m2 = '0;
    for (int unsigned y = y0; y <= need_row; y++) begin
      for (int unsigned x = x0; x <= need_col; x++) begin
        p = pix_hist[(y * w + x) % HIST_DEPTH];
        if (p[7:0] > m0) m0 = p[7:0];
        if (p[15:8] > m1) m1 = p[15:8];
        if (p[23:16] > m2) m2 = p[23:16];
      end
    end
    res.chan0_out  = m0;
    res.chan1_out  = m1;
    res.chan2_out  = m2;
    res.frame_last = (out_row == h - 1) && (out_col == w - 1);
    due_results_q.insert(due_results_q.size(), res);
    if (res.frame_last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_closed = 1'b1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) words_in <= words_in + 1;
  end

  always @(negedge clk) begin
    if (rst_n && !(in_ch.valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_words_q.size() > 0) begin
        in_ch.data  <= pixel_words_q.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          // long bursts now and then, otherwise short chop
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall patterns, one long hold-off
  // ---------------------------------------------------------------------------
  int cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [1:0] ready_mode = 2'd0;

  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) ready_mode <= 2'($urandom_range(0, 3));
    if (!hold_done && words_in >= 150 && pixel_words_q.size() >= 8) begin
      // fill the block up while the sender keeps offering words
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cyc % 7) < 4;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: field by field against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w, got_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_w = out_ch.data;
      results_seen <= results_seen + 1;
      if (got_w.frame_last) frames_seen <= frames_seen + 1;
      if (due_results_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result word %h", got_w);
      end else begin
        exp_w = due_results_q.pop_front();
        if (got_w.chan0_out !== exp_w.chan0_out || got_w.chan1_out !== exp_w.chan1_out ||
            got_w.chan2_out !== exp_w.chan2_out || got_w.frame_last !== exp_w.frame_last) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("result mismatch: exp c0=%h c1=%h c2=%h last=%b got c0=%h c1=%h c2=%h last=%b",
                     exp_w.chan0_out, exp_w.chan1_out, exp_w.chan2_out, exp_w.frame_last,
                     got_w.chan0_out, got_w.chan1_out, got_w.chan2_out, got_w.frame_last);
        end
      end
    end
  end

  // watchdog: only counts while work is outstanding
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pixel_words_q.size() == 0 && due_results_q.size() == 0 && !in_ch.valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    // mirror in the predictor, a write restarts the frame
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = val & 11'h7ff;
      CFG_IMAGE_HEIGHT: reg_height = val & 11'h7ff;
      CFG_WINDOW_SIZE:  reg_wsize  = val & 5'h1f;
      default: ;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic queue_word(input in_word_t wd);
    pixel_words_q.insert(pixel_words_q.size(), wd);
    dilate_step(wd);
  endtask

  // pix_mode: 0 random, 1 all zero, 2 all ones, 3 alternating extremes
  task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned ws,
                           input int pix_mode);
    in_word_t wd;
    int unsigned npix;
    reg_write(CFG_IMAGE_WIDTH, w);
    reg_write(CFG_IMAGE_HEIGHT, h);
    reg_write(CFG_WINDOW_SIZE, ws);
    npix = eff_w() * eff_h();
    for (int unsigned k = 0; k < npix; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        wd = '0;
        wd.operation = OP_DRAIN;
        wd.chan0_in = 8'($urandom); wd.chan1_in = 8'($urandom); wd.chan2_in = 8'($urandom);
        queue_word(wd);
      end
      wd.operation = OP_PIXEL;
      case (pix_mode)
        1: {wd.chan2_in, wd.chan1_in, wd.chan0_in} = 24'h000000;
        2: {wd.chan2_in, wd.chan1_in, wd.chan0_in} = 24'hffffff;
        3: {wd.chan2_in, wd.chan1_in, wd.chan0_in} = k[0] ? 24'hff00ff : 24'h00ff00;
        default: {wd.chan2_in, wd.chan1_in, wd.chan0_in} = 24'($urandom);
      endcase
      queue_word(wd);
    end
    // flush: drains mixed with stray pixels, which the block drops past the last row
    frame_closed = 1'b0;
    for (int guard = 0; !frame_closed && guard < 4 * DEF_MAX_WIDTH * (2 * DEF_MAX_RADIUS + 2);
         guard++) begin
      wd = '0;
      wd.operation = ($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN;
      {wd.chan2_in, wd.chan1_in, wd.chan0_in} = 24'($urandom);
      queue_word(wd);
    end
    // sometimes a few words of a next frame that a register write then cancels
    if ($urandom_range(0, 3) == 0) begin
      for (int j = 0; j < $urandom_range(1, 3); j++) begin
        wd.operation = OP_PIXEL;
        {wd.chan2_in, wd.chan1_in, wd.chan0_in} = 24'($urandom);
        queue_word(wd);
      end
    end
    wait (pixel_words_q.size() == 0 && due_results_q.size() == 0);
    @(negedge clk);
    wait (!in_ch.valid);
    repeat (CFG_SETTLE) @(negedge clk);
    phases_run++;
  endtask

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) pix_hist[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest frames, extreme values, zero and saturating registers
    run_frame(1, 1, 0, 2);
    run_frame(0, 0, 1, 1);
    run_frame(3, 2, 2, 3);
    run_frame(4, 3, 3, 0);
    run_frame(5, 5, 31, 3);
    run_frame(2, 6, 30, 2);

    // random frames, mostly small
    while (words_in < 400) begin
      if ($urandom_range(0, 15) == 0)
        run_frame($urandom_range(0, 40), $urandom_range(0, 3), $urandom_range(0, 31), 0);
      else
        run_frame($urandom_range(1, 9), $urandom_range(1, 7), $urandom_range(0, 31), 0);
    end

    repeat (200) @(negedge clk);
    $display("covered %0d frame settings, %0d words in, %0d results, %0d frames closed",
             phases_run, words_in, results_seen, frames_seen);
    if (errors == 0 && due_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", errors, due_results_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/rgbsd_pkg.sv
sv/rgbsd_if.sv
sv/rgbsd_cell.sv
sv/rgbsd_cell_row.sv
sv/rgb_square_dilation.sv
tb/sv/testbench.sv
